### src/mcsr_pkg.sv
package mcsr_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int VREF_W    = 13;
    localparam int MVPA_W    = 10;
    localparam int CUR_W     = 20;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = VREF_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VREF_MV    = 2'd0,
        REG_MV_PER_AMP = 2'd1
    } t_reg_idx;

    localparam logic [VREF_W-1:0] VREF_RST = VREF_W'(3300);
    localparam logic [MVPA_W-1:0] MVPA_RST = MVPA_W'(100);

    // Window and converter scaling
    localparam int WINDOW_DEF = 31;
    localparam int ADC_STEPS  = 1 << SAMPLE_W;
    localparam int MA_PER_A   = 1000;
    localparam int MA_W       = $clog2(MA_PER_A + 1);
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int P1_W       = MAG_W + VREF_W;
    localparam int P2_W       = P1_W + MA_W;
    localparam int DEN_SHIFT  = $clog2(2 * ADC_STEPS);
    localparam int NUM_W      = P2_W - DEN_SHIFT;
    localparam int STEP_W     = $clog2(NUM_W);

    localparam int OUT_MAX     = (1 << (CUR_W - 1)) - 1;
    localparam int OUT_MIN_MAG = 1 << (CUR_W - 1);

    // Median handoff from the sorter to the queue
    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] code;
    } t_med_push;

    // Queue status seen by the arithmetic side
    typedef struct packed {
        logic                empty;
        logic                full;
        logic [SAMPLE_W-1:0] code;
    } t_q_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

### src/median_current_sensor_reader_core.sv
// Median current reader for a Hall sensor. Pulse i_start with a 10-bit ADC code
// on i_sample; the sample is taken on any edge where o_busy is low, normally one
// sample every cycle. Every WINDOW samples (31 by default) the block reports the
// median code of the window and the current it stands for, in signed milliamps
// truncated toward zero and saturated to 20 bits, then starts a fresh window.
// The result appears for exactly one cycle with o_valid high and cannot be held
// off, so capture it on that cycle. The median comes from an insertion-sorted
// row of cells that takes one sample per cycle while o_busy is low; the current
// is worked out by a separate unit (two multiplies and a 23-step restoring
// divide by mv_per_amp) that steps through its idle, multiply, divide and output
// states, then registers o_valid. A two-entry queue sits between the
// sorter and the arithmetic; o_busy rises only when both entries are waiting,
// which needs windows shorter than the arithmetic time. Write vref_mv (index 0)
// and mv_per_amp (index 1) only while no window result is outstanding; the
// config channel is always ready. A zero mv_per_amp reports zero current.
module median_current_sensor_reader_core
    import mcsr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [SAMPLE_W-1:0]     i_sample,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [CUR_W-1:0] o_current_ma,
    output logic [SAMPLE_W-1:0]     o_median_code
);

    logic [VREF_W-1:0] r_vref_mv;
    logic [MVPA_W-1:0] r_mv_per_amp;
    logic              take;
    logic              pop;
    t_med_push         med;
    t_q_stat           q_stat;

    // Accept a sample beat unless the queue is full.
    assign o_busy      = q_stat.full;
    assign take        = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes drop the beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref_mv    <= VREF_RST;
            r_mv_per_amp <= MVPA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_VREF_MV:    r_vref_mv    <= i_cfg_data[VREF_W-1:0];
                REG_MV_PER_AMP: r_mv_per_amp <= i_cfg_data[MVPA_W-1:0];
                default: begin
                    r_vref_mv    <= r_vref_mv;
                    r_mv_per_amp <= r_mv_per_amp;
                end
            endcase
        end
    end

    // Front: sorted window, hands the median on when the window closes.
    mcsr_sorter #(
        .WINDOW(WINDOW)
    ) u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_sample(i_sample),
        .o_med   (med)
    );

    // Hold medians until the arithmetic is free.
    mcsr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_med  (med),
        .i_pop  (pop),
        .o_stat (q_stat)
    );

    // Back: code to milliamps.
    mcsr_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q          (q_stat),
        .o_pop        (pop),
        .i_vref_mv    (r_vref_mv),
        .i_mv_per_amp (r_mv_per_amp),
        .o_strobe     (o_valid),
        .o_current_ma (o_current_ma),
        .o_median_code(o_median_code)
    );

`ifndef SYNTHESIS
    // The converter finishes at most one window per pass, so results never abut.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe high on two cycles in a row");

    // A closing window never meets a full queue.
    a_no_lost_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        med.push |-> !q_stat.full)
        else $error("median pushed into a full queue");

    // Zero sensitivity reports zero current.
    a_zero_sens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mv_per_amp == '0)) |-> (o_current_ma == '0))
        else $error("nonzero current with zero sensitivity");
`endif

endmodule

### src/mcsr_sorter.sv
module mcsr_sorter
    import mcsr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_med_push           o_med
);

    localparam int CW   = $clog2(WINDOW);
    localparam int MED  = (WINDOW - 1) / 2;
    localparam logic [CW-1:0] LAST = CW'(WINDOW - 1);

    logic [SAMPLE_W-1:0] r_cell [WINDOW];
    logic [SAMPLE_W-1:0] n_cell [WINDOW];
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       n_fill;
    logic [WINDOW-1:0]   above;

    // Insert the new sample into the sorted row: cells above it shift up one place.
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            above[i] = (CW'(i) >= r_fill) || (r_cell[i] > i_sample);
        end
        n_cell[0] = (above[0]) ? i_sample : r_cell[0];
        for (int i = 1; i < WINDOW; i++) begin
            if ((CW'(i) <= r_fill) && above[i]) begin
                n_cell[i] = above[i-1] ? r_cell[i-1] : i_sample;
            end else begin
                n_cell[i] = r_cell[i];
            end
        end
    end

    assign n_fill       = (r_fill == LAST) ? '0 : r_fill + CW'(1);
    assign o_med.push   = i_take && (r_fill == LAST);
    assign o_med.code   = n_cell[MED];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_take) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cell <= n_cell;
        end
    end

endmodule

### src/mcsr_queue.sv
module mcsr_queue
    import mcsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_med_push i_med,
    input  logic      i_pop,
    output t_q_stat   o_stat
);

    logic [SAMPLE_W-1:0] r_slot [2];
    logic                r_wr;
    logic                r_rd;
    logic [1:0]          r_cnt;
    logic                wr_en;
    logic                rd_en;

    assign wr_en = i_med.push && (r_cnt != 2'd2);
    assign rd_en = i_pop && (r_cnt != 2'd0);

    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.code  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (rd_en) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr] <= i_med.code;
        end
    end

endmodule

### src/mcsr_convert.sv
module mcsr_convert
    import mcsr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_q_stat                 i_q,
    output logic                    o_pop,
    input  logic [VREF_W-1:0]       i_vref_mv,
    input  logic [MVPA_W-1:0]       i_mv_per_amp,
    output logic                    o_strobe,
    output logic signed [CUR_W-1:0] o_current_ma,
    output logic [SAMPLE_W-1:0]     o_median_code
);

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);
    localparam logic [SAMPLE_W:0] STEPS_2X  = (SAMPLE_W + 1)'(ADC_STEPS);

    t_back_state         r_state;
    t_back_state         n_state;
    logic [SAMPLE_W-1:0] r_med;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [P1_W-1:0]     r_p1;
    logic [NUM_W-1:0]    r_quo;
    logic [MVPA_W-1:0]   r_rem;
    logic [STEP_W-1:0]   r_step;
    logic                r_strobe;
    logic [CUR_W-1:0]    r_cur;
    logic [SAMPLE_W-1:0] r_code;

    logic                n_strobe;
    logic [SAMPLE_W:0]   twice;
    logic [P2_W-1:0]     p2;
    logic [MVPA_W:0]     trial;
    logic [MVPA_W:0]     dvsr;
    logic                ge;
    logic [MVPA_W:0]     diff;
    logic [NUM_W-1:0]    lim;
    logic [CUR_W-1:0]    mag20;
    logic [CUR_W-1:0]    cur;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q.empty) begin
                    n_state = BK_MUL1;
                end
            end
            BK_MUL1: n_state = BK_MUL2;
            BK_MUL2: n_state = BK_DIV;
            BK_DIV: begin
                if (r_step == STEP_LAST) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT:  n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop    = 1'b0;
        n_strobe = 1'b0;
        case (r_state)
            BK_IDLE: o_pop    = !i_q.empty;
            BK_OUT:  n_strobe = 1'b1;
            default: begin
                o_pop    = 1'b0;
                n_strobe = 1'b0;
            end
        endcase
    end

    // Datapath
    assign twice = {i_q.code, 1'b0};
    assign p2    = P2_W'(r_p1) * P2_W'(MA_PER_A);
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign dvsr  = {1'b0, i_mv_per_amp};
    assign ge    = (trial >= dvsr);
    assign diff  = trial - dvsr;

    always_comb begin
        if (r_neg) begin
            lim = (r_quo > NUM_W'(OUT_MIN_MAG)) ? NUM_W'(OUT_MIN_MAG) : r_quo;
        end else begin
            lim = (r_quo > NUM_W'(OUT_MAX)) ? NUM_W'(OUT_MAX) : r_quo;
        end
        mag20 = lim[CUR_W-1:0];
        if (i_mv_per_amp == '0) begin
            cur = '0;
        end else if (r_neg) begin
            cur = -mag20;
        end else begin
            cur = mag20;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_med <= i_q.code;
                r_neg <= (twice < STEPS_2X);
                r_mag <= (twice < STEPS_2X) ? MAG_W'(STEPS_2X - twice)
                                            : MAG_W'(twice - STEPS_2X);
            end
            BK_MUL1: begin
                r_p1 <= P1_W'(r_mag) * P1_W'(i_vref_mv);
            end
            BK_MUL2: begin
                r_quo  <= p2[P2_W-1:DEN_SHIFT];
                r_rem  <= '0;
                r_step <= '0;
            end
            BK_DIV: begin
                r_rem  <= ge ? diff[MVPA_W-1:0] : trial[MVPA_W-1:0];
                r_quo  <= {r_quo[NUM_W-2:0], ge};
                r_step <= r_step + STEP_W'(1);
            end
            BK_OUT: begin
                r_cur  <= cur;
                r_code <= r_med;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_current_ma  = r_cur;
    assign o_median_code = r_code;

endmodule
